>>> sv/mt19937_word_generator_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef MT19937_WORD_GENERATOR_MACROS_SVH
`define MT19937_WORD_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTWG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtwg check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtwg check failed");

`endif

>>> sv/mtwg_pkg.sv
package mtwg_pkg;

    localparam int WORD_W          = 32;
    localparam int STATE_WORDS_DEF = 624;
    localparam int TWIST_OFFSET    = 397;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_HEAD,
        ST_TW_PRIME,
        ST_TW_RUN,
        ST_DRAW,
        ST_DELIVER
    } state_t;

    // Datapath controls driven by the sequencer.
    typedef struct packed {
        logic seed_step;
        logic seed_first;
        logic load_cur;
        logic load_out;
    } ctrl_t;

    // One step of the twist recurrence.
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> sv/mtwg_ram.sv
module mtwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> sv/mtwg_ctrl.sv
module mtwg_ctrl #(
    parameter int STATE_WORDS = mtwg_pkg::STATE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           reseed,
    output logic                           in_stall,
    input  logic                           out_free,
    output mtwg_pkg::ctrl_t                ctl,
    output logic                           we,
    output logic [$clog2(STATE_WORDS)-1:0] waddr,
    output logic [$clog2(STATE_WORDS)-1:0] raddr_a,
    output logic [$clog2(STATE_WORDS)-1:0] raddr_b
);

    import mtwg_pkg::*;

    localparam int AW = $clog2(STATE_WORDS);
    localparam int IW = $clog2(STATE_WORDS + 2);

    localparam logic [AW-1:0] LAST_ADDR    = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] FAR_SPLIT    = AW'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IW-1:0] IDX_USED_UP  = IW'(STATE_WORDS);
    localparam logic [IW-1:0] IDX_UNSEEDED = IW'(STATE_WORDS + 1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   idx_addr;
    logic [AW-1:0]   cnt_inc;
    logic            accept;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == LAST_ADDR) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] far_addr(input logic [AW-1:0] x);
        return (x >= FAR_SPLIT) ? x - FAR_SPLIT : x + AW'(TWIST_OFFSET);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign idx_addr = idx_reg[AW-1:0];
    assign cnt_inc  = wrap_inc(cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (reseed || idx_reg == IDX_UNSEEDED)
                    begin
                        state_next = ST_SEED;
                    end
                    else if (idx_reg >= IDX_USED_UP)
                    begin
                        state_next = ST_TW_HEAD;
                    end
                    else
                    begin
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_SEED:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_TW_HEAD;
                end
            end
            ST_TW_HEAD:
            begin
                state_next = ST_TW_PRIME;
            end
            ST_TW_PRIME:
            begin
                state_next = ST_TW_RUN;
            end
            ST_TW_RUN:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        unique case (state_reg)
            ST_SEED:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == LAST_ADDR)
                begin
                    idx_next = IDX_USED_UP;
                end
            end
            ST_TW_HEAD:
            begin
                cnt_next = '0;
            end
            ST_TW_RUN:
            begin
                cnt_next = cnt_inc;
                if (cnt_reg == LAST_ADDR)
                begin
                    idx_next = '0;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        ctl     = '0;
        we      = 1'b0;
        waddr   = cnt_reg;
        raddr_a = idx_addr;
        raddr_b = '0;
        unique case (state_reg)
            ST_SEED:
            begin
                we             = 1'b1;
                ctl.seed_step  = 1'b1;
                ctl.seed_first = (cnt_reg == '0);
            end
            ST_TW_HEAD:
            begin
                raddr_a = '0;
            end
            ST_TW_PRIME:
            begin
                ctl.load_cur = 1'b1;
                raddr_a      = cnt_inc;
                raddr_b      = far_addr(cnt_reg);
            end
            ST_TW_RUN:
            begin
                we             = 1'b1;
                ctl.load_cur   = 1'b1;
                raddr_a        = wrap_inc(cnt_inc);
                raddr_b        = far_addr(cnt_inc);
            end
            ST_DELIVER:
            begin
                ctl.load_out = out_free;
            end
            default:
            begin
                raddr_a = idx_addr;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= IDX_UNSEEDED;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> sv/mtwg_dpath.sv
module mtwg_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtwg_pkg::ctrl_t             ctl,
    input  logic                        cfg_valid,
    input  logic [mtwg_pkg::WORD_W-1:0] seed,
    input  logic [mtwg_pkg::WORD_W-1:0] rdata_a,
    input  logic [mtwg_pkg::WORD_W-1:0] rdata_b,
    output logic [mtwg_pkg::WORD_W-1:0] wdata,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [mtwg_pkg::WORD_W-1:0] random_word,
    output logic                        out_free
);

    import mtwg_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] hold_reg;
    logic [WORD_W-1:0] word_out_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] product;

    // Low half of the seeding product; the previous word is always registered.
    assign product = hold_reg * SEED_MULT;

    always_comb
    begin
        if (ctl.seed_step)
        begin
            wdata = ctl.seed_first ? seed_reg : product;
        end
        else
        begin
            wdata = twist_word(hold_reg, rdata_a, rdata_b);
        end
    end

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign random_word = word_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= seed;
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.seed_step)
        begin
            hold_reg <= wdata;
        end
        else if (ctl.load_cur)
        begin
            hold_reg <= rdata_a;
        end
        if (ctl.load_out)
        begin
            word_out_reg <= temper(rdata_a);
        end
    end

endmodule

>>> sv/mt19937_word_generator.sv
// MT19937 word source. Each input transaction yields one tempered 32-bit word
// on the output channel. The twist store lives in a single STATE_WORDS x 32
// synchronous RAM with one write port and two registered read ports. In an
// ordinary draw the read of the store is issued in the accepting cycle, and
// the registered read word is tempered into the output register once the
// output side is free. When the store is used up, the draw first runs the
// twist pass, which updates one word per cycle (two reads and one write of
// the RAM per word), and then re-reads word 0. The first draw after reset,
// and any draw with reseed set, also refills the store from the seed register
// at one word per cycle. The seed register resets to 4357 and only takes
// effect on the next seeding. The output register frees the input side: a
// new transaction can be accepted while the previous word is still stalled
// at the output.
module mt19937_word_generator #(
    parameter int STATE_WORDS = mtwg_pkg::STATE_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        reseed,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mtwg_pkg::WORD_W-1:0] random_word,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mtwg_pkg::WORD_W-1:0] seed
);

    import mtwg_pkg::*;

    localparam int AW = $clog2(STATE_WORDS);

    ctrl_t             ctl;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    logic              out_free;

    // The seed register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer: seeding sweep, twist sweep and draw handling.
    mtwg_ctrl #(
        .STATE_WORDS(STATE_WORDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .reseed   (reseed),
        .in_stall (in_stall),
        .out_free (out_free),
        .ctl      (ctl),
        .we       (we),
        .waddr    (waddr),
        .raddr_a  (raddr_a),
        .raddr_b  (raddr_b)
    );

    // Twist store. Port A reads the next word in sequence or the word being
    // drawn; port B reads the word at the middle offset during a twist.
    mtwg_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STATE_WORDS)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Seed multiply, twist recurrence, tempering and the output register.
    mtwg_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cfg_valid   (cfg_valid & cfg_ready),
        .seed        (seed),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b),
        .wdata       (wdata),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .random_word (random_word),
        .out_free    (out_free)
    );

endmodule

>>> sv/mtwg_checker.sv
`include "mt19937_word_generator_macros.svh"

module mtwg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [mtwg_pkg::WORD_W-1:0] random_word
);

    // A stalled result word holds until it is taken.
    `MTWG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(random_word))

    // One transaction at a time: acceptance makes the input side busy.
    `MTWG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A new result only appears at the end of a transaction in flight.
    `MTWG_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // The input side frees up only together with a delivered result.
    `MTWG_ASSERT_NOW(a_free_with_result, clk, rst_n, $fell(in_stall), out_valid)

endmodule

bind mt19937_word_generator mtwg_checker u_mtwg_checker (.*);
